// ----- hw/rtl/wwn_pkg.sv -----
`default_nettype none

package wwn_pkg;

    // build-time sizing
    localparam int NUM_WAVES  = 5;
    localparam int SINE_DEPTH = 1024;
    localparam int WAVE_ROWS  = 16;
    localparam int ROW_W      = $clog2(WAVE_ROWS);

    // field widths
    localparam int COORD_W = 24;
    localparam int NRM_W   = 16;
    localparam int NRMZ_W  = 15;

    // wave table widths
    localparam int DIR_W   = 30;
    localparam int SLOPE_W = 22;

    // phase and sine lookup
    localparam int PHASE_W    = DIR_W + COORD_W;
    localparam int PHASE_KEEP = 40;
    localparam int OFS_W      = $clog2(SINE_DEPTH);
    localparam int IDX_W      = OFS_W + 2;
    localparam int ADDR_W     = OFS_W + 1;
    localparam int TAB_W      = 16;
    localparam int SINE_W     = TAB_W + 1;

    // slope sums and normal vector
    localparam int PROD_W   = SLOPE_W + SINE_W;
    localparam int SUM_W    = PROD_W + $clog2(NUM_WAVES + 1);
    localparam int FLOOR_SH = 19;
    localparam int FLOOR_W  = SUM_W - FLOOR_SH;
    localparam int VEC_W    = FLOOR_W + $clog2(NUM_WAVES + 1);
    localparam int SQ_W     = 2 * VEC_W + 2;
    localparam int RT_W     = VEC_W + 1;

    // normalizing divide
    localparam int FRAC_SH = 14;
    localparam int QUO_W   = 15;
    localparam int DIV_W   = RT_W + FRAC_SH + 1;

    localparam longint VZ_VAL = longint'(NUM_WAVES) * longint'(NUM_WAVES) * 65536;

    typedef struct packed {
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [SLOPE_W-1:0] slope_x;
        logic signed [SLOPE_W-1:0] slope_y;
    } t_wave_row;

    typedef logic [TAB_W-1:0] t_sine_rom [SINE_DEPTH+1];

    function automatic t_wave_row wave_row(input logic [ROW_W-1:0] idx);
        t_wave_row row;
        row = '0;
        unique case (idx)
            ROW_W'(0): row = '{-30'sd111657381, -30'sd6529037, -22'sd274048, -22'sd16025};
            ROW_W'(1): row = '{-30'sd247428273, 30'sd226647834, -22'sd1214561, 22'sd1112555};
            ROW_W'(2): row = '{30'sd92947543, 30'sd182619583, 22'sd524693, 22'sd1030897};
            ROW_W'(3): row = '{30'sd442768117, 30'sd265408326, 22'sd326015, 22'sd195423};
            ROW_W'(4): row = '{-30'sd19951728, 30'sd166580886, -22'sd146907, 22'sd1226553};
            default:   row = '0;
        endcase
        return row;
    endfunction

    // quarter-wave entry: taylor series in q2.30, rounded to q1.15
    function automatic logic [TAB_W-1:0] sine_entry(input int k);
        longint unsigned theta;
        longint unsigned theta2;
        longint unsigned term;
        longint unsigned val;
        longint          acc;
        theta  = (longint'(k) * 64'd1686629713 + SINE_DEPTH / 2) / SINE_DEPTH;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        acc    = longint'(theta);
        term   = ((term * theta2) >> 30) / 6;
        acc    = acc - longint'(term);
        term   = ((term * theta2) >> 30) / 20;
        acc    = acc + longint'(term);
        term   = ((term * theta2) >> 30) / 42;
        acc    = acc - longint'(term);
        term   = ((term * theta2) >> 30) / 72;
        acc    = acc + longint'(term);
        term   = ((term * theta2) >> 30) / 110;
        acc    = acc - longint'(term);
        term   = ((term * theta2) >> 30) / 156;
        acc    = acc + longint'(term);
        if (acc < 0) begin
            acc = 0;
        end
        val = (longint'(acc) * 32768 + 64'd536870912) >> 30;
        if (val > 32768) begin
            val = 32768;
        end
        return TAB_W'(val);
    endfunction

    function automatic t_sine_rom sine_rom_init();
        t_sine_rom rom;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/water_wave_normal.sv -----
// water surface normal, one word in and one word out per cycle when not stalled
// pipeline depth is set mostly by the bit-per-stage square
// root (one root bit per stage) and the three bit-per-stage normalizing dividers
// throughput: one word per cycle; a stalled output freezes the whole pipe in place
// reset: synchronous active low, clears the pipeline valid bits; no clearing pass
`default_nettype none

module water_wave_normal (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [wwn_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [wwn_pkg::COORD_W-1:0]  i_y_coord,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [wwn_pkg::NRM_W-1:0]    o_normal_x,
    output logic signed [wwn_pkg::NRM_W-1:0]    o_normal_y,
    output logic [wwn_pkg::NRMZ_W-1:0]          o_normal_z
);
    import wwn_pkg::*;

    // stage map of the valid shift line
    localparam int WAVE_LAT = 4;
    localparam int SUM_IDX  = WAVE_LAT;
    localparam int VEC_IDX  = SUM_IDX + 1;
    localparam int SQ_IDX   = VEC_IDX + 1;
    localparam int SQS_IDX  = SQ_IDX + 1;
    localparam int RT_BASE  = SQS_IDX + 1;
    localparam int DIV_BASE = RT_BASE + RT_W;
    localparam int OUT_IDX  = DIV_BASE + 1 + QUO_W;
    localparam int TOTAL    = OUT_IDX + 1;

    // divider lanes: x, y and the constant z
    localparam int NCOMP  = 3;
    localparam int COMP_X = 0;
    localparam int COMP_Y = 1;
    localparam int COMP_Z = 2;

    localparam logic [SQ_W-1:0]  VZ_SQ  = SQ_W'(VZ_VAL * VZ_VAL);
    localparam logic [VEC_W-1:0] VZ_MAG = VEC_W'(VZ_VAL);

    logic               adv;
    logic [TOTAL-1:0]   r_vld;

    // global advance: everything moves unless a finished word is held
    assign o_valid = r_vld[TOTAL-1];
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[TOTAL-2:0], i_valid};
        end
    end

    // per-wave phase, sine lookup and slope products
    logic signed [PROD_W-1:0] prod_x [NUM_WAVES];
    logic signed [PROD_W-1:0] prod_y [NUM_WAVES];

    for (genvar w = 0; w < NUM_WAVES; w++) begin : g_wave
        wwn_wave u_wave (
            .i_clk     (i_clk),
            .i_en      (adv),
            .i_row     (ROW_W'(w)),
            .i_x_coord (i_x_coord),
            .i_y_coord (i_y_coord),
            .o_prod_x  (prod_x[w]),
            .o_prod_y  (prod_y[w])
        );
    end

    // slope sums, floored to q.16
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int w = 0; w < NUM_WAVES; w++) begin
            sum_x = sum_x + SUM_W'(prod_x[w]);
            sum_y = sum_y + SUM_W'(prod_y[w]);
        end
    end

    logic signed [FLOOR_W-1:0]  r_fx;
    logic signed [FLOOR_W-1:0]  r_fy;
    logic signed [VEC_W-1:0]    r_vx;
    logic signed [VEC_W-1:0]    r_vy;
    logic signed [VEC_W-1:0]    r_sq_vx;
    logic signed [VEC_W-1:0]    r_sq_vy;
    logic [2*VEC_W-1:0]         r_sqx;
    logic [2*VEC_W-1:0]         r_sqy;
    logic [SQ_W-1:0]            r_sqsum;
    logic [VEC_W-1:0]           r_mx;
    logic [VEC_W-1:0]           r_my;
    logic                       r_nx;
    logic                       r_ny;

    logic signed [2*VEC_W-1:0]  ext_x;
    logic signed [2*VEC_W-1:0]  ext_y;
    logic signed [2*VEC_W-1:0]  sq_x;
    logic signed [2*VEC_W-1:0]  sq_y;

    assign ext_x = (2*VEC_W)'(r_vx);
    assign ext_y = (2*VEC_W)'(r_vy);
    assign sq_x  = ext_x * ext_x;
    assign sq_y  = ext_y * ext_y;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fx    <= sum_x[SUM_W-1:FLOOR_SH];
            r_fy    <= sum_y[SUM_W-1:FLOOR_SH];
            // tangent cross product scales the slopes by the wave count
            r_vx    <= VEC_W'(r_fx) * $signed(VEC_W'(NUM_WAVES));
            r_vy    <= VEC_W'(r_fy) * $signed(VEC_W'(NUM_WAVES));
            r_sqx   <= sq_x;
            r_sqy   <= sq_y;
            r_sq_vx <= r_vx;
            r_sq_vy <= r_vy;
            r_sqsum <= SQ_W'(r_sqx) + SQ_W'(r_sqy) + VZ_SQ;
            r_nx    <= r_sq_vx[VEC_W-1];
            r_ny    <= r_sq_vy[VEC_W-1];
            r_mx    <= r_sq_vx[VEC_W-1] ? VEC_W'(-r_sq_vx) : VEC_W'(r_sq_vx);
            r_my    <= r_sq_vy[VEC_W-1] ? VEC_W'(-r_sq_vy) : VEC_W'(r_sq_vy);
        end
    end

    // digit-by-digit square root, one root bit per stage
    logic [RT_W+1:0]  r_rt_rem  [RT_W];
    logic [RT_W-1:0]  r_rt_root [RT_W];
    logic [SQ_W-1:0]  r_rt_val  [RT_W];
    logic [VEC_W-1:0] r_rt_mx   [RT_W];
    logic [VEC_W-1:0] r_rt_my   [RT_W];
    logic             r_rt_nx   [RT_W];
    logic             r_rt_ny   [RT_W];

    for (genvar s = 0; s < RT_W; s++) begin : g_root
        localparam int B = RT_W - 1 - s;

        logic [RT_W+1:0]  rem_in;
        logic [RT_W-1:0]  root_in;
        logic [SQ_W-1:0]  val_in;
        logic [VEC_W-1:0] mx_in;
        logic [VEC_W-1:0] my_in;
        logic             nx_in;
        logic             ny_in;
        logic [RT_W+1:0]  rem_sh;
        logic [RT_W+1:0]  trial;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = r_sqsum;
            assign mx_in   = r_mx;
            assign my_in   = r_my;
            assign nx_in   = r_nx;
            assign ny_in   = r_ny;
        end else begin : g_next
            assign rem_in  = r_rt_rem[s-1];
            assign root_in = r_rt_root[s-1];
            assign val_in  = r_rt_val[s-1];
            assign mx_in   = r_rt_mx[s-1];
            assign my_in   = r_rt_my[s-1];
            assign nx_in   = r_rt_nx[s-1];
            assign ny_in   = r_rt_ny[s-1];
        end

        assign rem_sh = {rem_in[RT_W-1:0], val_in[2*B+1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (rem_sh >= trial) begin
                    r_rt_rem[s]  <= rem_sh - trial;
                    r_rt_root[s] <= {root_in[RT_W-2:0], 1'b1};
                end else begin
                    r_rt_rem[s]  <= rem_sh;
                    r_rt_root[s] <= {root_in[RT_W-2:0], 1'b0};
                end
                r_rt_val[s] <= val_in;
                r_rt_mx[s]  <= mx_in;
                r_rt_my[s]  <= my_in;
                r_rt_nx[s]  <= nx_in;
                r_rt_ny[s]  <= ny_in;
            end
        end
    end

    // dividend = mag * 2^14 + len / 2, for round half away from zero
    logic [RT_W-1:0]  root_fin;
    logic [RT_W-1:0]  len;
    logic [VEC_W-1:0] mag [NCOMP];

    assign root_fin     = r_rt_root[RT_W-1];
    assign len          = (root_fin == '0) ? RT_W'(1) : root_fin;
    assign mag[COMP_X]  = r_rt_mx[RT_W-1];
    assign mag[COMP_Y]  = r_rt_my[RT_W-1];
    assign mag[COMP_Z]  = VZ_MAG;

    logic [DIV_W-1:0] r_dp_rem [NCOMP];
    logic             r_dp_neg [NCOMP];
    logic [RT_W-1:0]  r_dp_len;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < NCOMP; c++) begin
                r_dp_rem[c] <= (DIV_W'(mag[c]) << FRAC_SH) + DIV_W'(len >> 1);
            end
            r_dp_neg[COMP_X] <= r_rt_nx[RT_W-1];
            r_dp_neg[COMP_Y] <= r_rt_ny[RT_W-1];
            r_dp_neg[COMP_Z] <= 1'b0;
            r_dp_len         <= len;
        end
    end

    // restoring division, one quotient bit per stage, three lanes side by side
    logic [DIV_W-1:0] r_dv_rem [NCOMP][QUO_W];
    logic [QUO_W-1:0] r_dv_quo [NCOMP][QUO_W];
    logic             r_dv_neg [NCOMP][QUO_W];
    logic [RT_W-1:0]  r_dv_len [QUO_W];

    for (genvar d = 0; d < QUO_W; d++) begin : g_div
        localparam int K = QUO_W - 1 - d;

        logic [RT_W-1:0]  len_in;
        logic [DIV_W-1:0] dvs;

        if (d == 0) begin : g_len_first
            assign len_in = r_dp_len;
        end else begin : g_len_next
            assign len_in = r_dv_len[d-1];
        end

        assign dvs = DIV_W'(len_in) << K;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_len[d] <= len_in;
            end
        end

        for (genvar c = 0; c < NCOMP; c++) begin : g_lane
            logic [DIV_W-1:0] rem_in;
            logic [QUO_W-1:0] quo_in;
            logic             neg_in;

            if (d == 0) begin : g_first
                assign rem_in = r_dp_rem[c];
                assign quo_in = '0;
                assign neg_in = r_dp_neg[c];
            end else begin : g_next
                assign rem_in = r_dv_rem[c][d-1];
                assign quo_in = r_dv_quo[c][d-1];
                assign neg_in = r_dv_neg[c][d-1];
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    if (rem_in >= dvs) begin
                        r_dv_rem[c][d] <= rem_in - dvs;
                        r_dv_quo[c][d] <= quo_in | (QUO_W'(1) << K);
                    end else begin
                        r_dv_rem[c][d] <= rem_in;
                        r_dv_quo[c][d] <= quo_in;
                    end
                    r_dv_neg[c][d] <= neg_in;
                end
            end
        end
    end

    // output register: sign restored
    logic [QUO_W-1:0] q_x;
    logic [QUO_W-1:0] q_y;
    logic [QUO_W-1:0] q_z;

    assign q_x = r_dv_quo[COMP_X][QUO_W-1];
    assign q_y = r_dv_quo[COMP_Y][QUO_W-1];
    assign q_z = r_dv_quo[COMP_Z][QUO_W-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_normal_x <= r_dv_neg[COMP_X][QUO_W-1] ? -$signed(NRM_W'(q_x))
                                                    : $signed(NRM_W'(q_x));
            o_normal_y <= r_dv_neg[COMP_Y][QUO_W-1] ? -$signed(NRM_W'(q_y))
                                                    : $signed(NRM_W'(q_y));
            o_normal_z <= NRMZ_W'(q_z);
        end
    end

    // a held output word freezes every stage
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved while output held");

    // z term keeps the length above zero
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_BASE-1] |-> root_fin != '0)
        else $error("square root of normal length is zero");

    a_z_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_z != '0) && (o_normal_z <= NRMZ_W'(16384)))
        else $error("normal z out of range");

    a_x_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x <= 16'sd16384) && (o_normal_x >= -16'sd16384))
        else $error("normal x out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/wwn_wave.sv -----
`default_nettype none

module wwn_wave (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [wwn_pkg::ROW_W-1:0]           i_row,
    input  logic signed [wwn_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [wwn_pkg::COORD_W-1:0]  i_y_coord,
    output logic signed [wwn_pkg::PROD_W-1:0]   o_prod_x,
    output logic signed [wwn_pkg::PROD_W-1:0]   o_prod_y
);
    import wwn_pkg::*;

    localparam t_sine_rom SineRom = sine_rom_init();

    t_wave_row                 row;
    logic signed [PHASE_W-1:0] mul_x;
    logic signed [PHASE_W-1:0] mul_y;
    logic [PHASE_KEEP-1:0]     phase;
    logic [IDX_W-1:0]          idx;
    logic [OFS_W-1:0]          ofs;
    logic signed [SINE_W-1:0]  sine_val;

    logic [PHASE_KEEP-1:0]     r_ph_x;
    logic [PHASE_KEEP-1:0]     r_ph_y;
    logic [ADDR_W-1:0]         r_addr;
    logic                      r_neg_a;
    logic [TAB_W-1:0]          r_tab;
    logic                      r_neg_t;

    assign row   = wave_row(i_row);
    assign mul_x = PHASE_W'(row.dir_x) * PHASE_W'(i_x_coord);
    assign mul_y = PHASE_W'(row.dir_y) * PHASE_W'(i_y_coord);

    // only the fractional turn matters, integer turns wrap away
    assign phase = r_ph_x + r_ph_y;
    assign idx   = phase[PHASE_KEEP-1 -: IDX_W];
    assign ofs   = idx[OFS_W-1:0];

    assign sine_val = r_neg_t ? -$signed(SINE_W'(r_tab)) : $signed(SINE_W'(r_tab));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph_x  <= mul_x[PHASE_KEEP-1:0];
            r_ph_y  <= mul_y[PHASE_KEEP-1:0];
            // odd quadrants run the table backwards
            r_addr  <= idx[OFS_W] ? (ADDR_W'(SINE_DEPTH) - ADDR_W'(ofs)) : ADDR_W'(ofs);
            r_neg_a <= idx[OFS_W+1];
            r_tab   <= SineRom[r_addr];
            r_neg_t <= r_neg_a;
            o_prod_x <= PROD_W'(row.slope_x) * PROD_W'(sine_val);
            o_prod_y <= PROD_W'(row.slope_y) * PROD_W'(sine_val);
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import wwn_pkg::*;

    localparam int WAVES      = 5;
    localparam int DEPTH      = 1024;
    localparam int STALL_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 80;    // pipe is 52 deep at five waves

    typedef struct {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic [NRMZ_W-1:0]       nz;
    } t_normal;

    // scoreboard: holds predicted normals in arrival order and counts mismatches
    class normal_scoreboard;
        t_normal pending[$];
        int      errors;
        int      checked;
        longint  dir_x_tab[WAVES];
        longint  dir_y_tab[WAVES];
        longint  slope_x_tab[WAVES];
        longint  slope_y_tab[WAVES];
        longint  qsine[DEPTH+1];

        function new();
            longint unsigned ang, ang2, t;
            longint acc;
            longint unsigned v;
            errors = 0;
            checked = 0;
            dir_x_tab   = '{-111657381, -247428273, 92947543, 442768117, -19951728};
            dir_y_tab   = '{-6529037, 226647834, 182619583, 265408326, 166580886};
            slope_x_tab = '{-274048, -1214561, 524693, 326015, -146907};
            slope_y_tab = '{-16025, 1112555, 1030897, 195423, 1226553};
            // quarter-wave sine, taylor series in q2.30 rounded to q15
            for (int k = 0; k <= DEPTH; k++) begin
                ang  = (longint'(k) * 64'd1686629713 + DEPTH / 2) / DEPTH;
                ang2 = (ang * ang) >> 30;
                t    = ang;
                acc  = longint'(ang);
                for (int n = 1; n <= 6; n++) begin
                    t = ((t * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) acc = acc - longint'(t);
                    else acc = acc + longint'(t);
                end
                if (acc < 0) acc = 0;
                v = (longint'(acc) * 32768 + 64'd536870912) >> 30;
                if (v > 32768) v = 32768;
                qsine[k] = longint'(v);
            end
        endfunction

        function longint wave_sine(longint unsigned turn_frac);
            longint unsigned idx;
            longint          s;
            idx = turn_frac >> 20;
            if (idx[10]) s = qsine[DEPTH - idx[9:0]];
            else s = qsine[idx[9:0]];
            return idx[11] ? -s : s;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint div_round(longint c, longint unsigned len);
            longint unsigned mag, q;
            mag = (c < 0) ? longint'(-c) : longint'(c);
            q   = ((mag << 14) + len / 2) / len;
            return (c < 0) ? -longint'(q) : longint'(q);
        endfunction

        // accepted input point: predict its normal
        function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
            longint          sx, sy, vx, vy, vz, ph, s;
            longint unsigned len;
            t_normal         e;
            sx = 0;
            sy = 0;
            for (int w = 0; w < WAVES; w++) begin
                ph = dir_x_tab[w] * longint'(x) + dir_y_tab[w] * longint'(y);
                s  = wave_sine((longint'(ph) >> 8) & 64'hFFFF_FFFF);
                sx = sx + slope_x_tab[w] * s;
                sy = sy + slope_y_tab[w] * s;
            end
            vx  = WAVES * (sx >>> 19);
            vy  = WAVES * (sy >>> 19);
            vz  = WAVES * WAVES * 65536;
            len = int_sqrt(longint'(vx * vx + vy * vy + vz * vz));
            if (len == 0) len = 1;
            e.nx = NRM_W'(div_round(vx, len));
            e.ny = NRM_W'(div_round(vy, len));
            e.nz = NRMZ_W'(div_round(vz, len));
            pending.insert(pending.size(), e);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_normal(logic signed [NRM_W-1:0] nx, logic signed [NRM_W-1:0] ny,
                          logic [NRMZ_W-1:0] nz);
            t_normal e;
            if (pending.size() == 0) begin
                report("output word with nothing expected");
                return;
            end
            e = pending.pop_front();
            checked++;
            if (nx !== e.nx) report($sformatf("normal_x %0d, want %0d", nx, e.nx));
            if (ny !== e.ny) report($sformatf("normal_y %0d, want %0d", ny, e.ny));
            if (nz !== e.nz) report($sformatf("normal_z %0d, want %0d", nz, e.nz));
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_x_coord = '0;
    logic signed [COORD_W-1:0] i_y_coord = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [NRM_W-1:0]   o_normal_x;
    logic signed [NRM_W-1:0]   o_normal_y;
    logic [NRMZ_W-1:0]         o_normal_z;

    normal_scoreboard sb = new();

    int send_idle_pct  = 0;   // chance the sender skips a cycle
    int recv_stall_pct = 0;   // chance the receiver stalls a cycle
    int points_sent    = 0;
    int quiet_cycles   = 0;

    water_wave_normal i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_x_coord  (i_x_coord),
        .i_y_coord  (i_y_coord),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_normal_x (o_normal_x),
        .o_normal_y (o_normal_y),
        .o_normal_z (o_normal_z)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver back-pressure, random per cycle at the current rate
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor both sides at the edge, plus a watchdog on stuck traffic
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_point(i_x_coord, i_y_coord);
            end
            if (o_valid && !i_stall) begin
                sb.check_normal(o_normal_x, o_normal_y, o_normal_z);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
                $display("water_wave_normal regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // one point: optional idle gap, then hold valid until the word is taken
    task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        do @(posedge i_clk); while (o_stall);
        points_sent++;
    endtask

    // mostly ordinary coordinates, some far out where the phase wraps
    task automatic send_random_point();
        logic signed [COORD_W-1:0] x, y;
        case ($urandom_range(3))
            0: begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end
            1: begin
                x = COORD_W'(int'($urandom_range(65536)) - 32768);
                y = COORD_W'(int'($urandom_range(65536)) - 32768);
            end
            default: begin
                x = COORD_W'(int'($urandom_range(1 << 20)) - (1 << 19));
                y = COORD_W'(int'($urandom_range(1 << 20)) - (1 << 19));
            end
        endcase
        send_point(x, y);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: origin (flat surface), extremes, single-bit and small steps
        send_point(0, 0);
        send_point(24'sh7FFFFF, 24'sh7FFFFF);
        send_point(-24'sh800000, -24'sh800000);
        send_point(24'sh7FFFFF, -24'sh800000);
        send_point(-24'sh800000, 24'sh7FFFFF);
        send_point(1, 0);
        send_point(0, 1);
        send_point(-1, -1);
        send_point(24'sh001000, 0);
        send_point(0, 24'sh001000);
        send_point(-24'sh001000, 24'sh000800);
        send_point(24'sh555555, 24'shAAAAAA);
        send_point(24'shAAAAAA, 24'sh555555);
        send_point(24'sh000400, 24'sh000C00);
        send_point(24'sh123456, -24'sh0FEDCB);

        // random phases with different idling mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int n = 0; n < 185; n++) begin
                send_random_point();
                // hold off once mid-phase until the pipe is empty
                if (phase == 2 && n == 90) begin
                    i_valid <= 1'b0;
                    wait_drained();
                end
            end
        end
        i_valid <= 1'b0;
        recv_stall_pct = 20;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d surface points, checked %0d normals, %0d mismatches",
                 points_sent, sb.checked, sb.errors);
        $display("covered coordinate extremes, wrapped phases and four idle/stall mixes");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("water_wave_normal regression: pass");
        end else begin
            $display("water_wave_normal regression: fail");
        end
        $finish;
    end

endmodule
